// ----- rtl/des_pkg.sv -----
// DES constants and helper functions: permutation tables, S-boxes, round function.
// Used by des_round_pipe and des_block_cipher_top.
`timescale 1ns / 1ps
package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned BlockW    = 64;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  localparam logic [0:15][1:0] RotTab = {
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [0:63][6:0] IpTab = {
    7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
    7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
    7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7
  };

  localparam logic [0:63][6:0] IpInvTab = {
    7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
    7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
    7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
    7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25
  };

  localparam logic [0:47][5:0] ExpTab = {
    6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd8,6'd9,6'd10,6'd11,
    6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,
    6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,
    6'd30,6'd31,6'd32,6'd1
  };

  localparam logic [0:31][5:0] PTab = {
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
    6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25
  };

  localparam logic [0:55][6:0] Pc1Tab = {
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
    7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
    7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
    7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4
  };

  localparam logic [0:47][5:0] Pc2Tab = {
    6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,6'd23,6'd19,6'd12,6'd4,
    6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,
    6'd51,6'd45,6'd33,6'd48,6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32
  };

  localparam logic [0:7][0:63][3:0] SboxTab = {
    {4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
     4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
     4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
     4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    {4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
     4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
     4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
     4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    {4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
     4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
     4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
     4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    {4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
     4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
     4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
     4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    {4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
     4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
     4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
     4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    {4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
     4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
     4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
     4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    {4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
     4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
     4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
     4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    {4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
     4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
     4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd5,4'd10,4'd3,4'd13,4'd8,4'd15,4'd6,
     4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // Table entries count from 1 at the MSB, as in the standard.
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IpTab[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_ipinv(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IpInvTab[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(Pc1Tab[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(Pc2Tab[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] h, input logic [1:0] n);
    return (n == 2'd1) ? {h[26:0], h[27]} : {h[25:0], h[27:26]};
  endfunction

  function automatic logic [31:0] round_f(input logic [31:0] half, input logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] r;
    for (int i = 0; i < 48; i++) x[47-i] = half[32 - int'(ExpTab[i])];
    x = x ^ sk;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31-i] = s[32 - int'(PTab[i])];
    return r;
  endfunction

endpackage

// ----- rtl/des_round_pipe.sv -----
// Sixteen-stage DES round pipeline with IP at entry and IP^-1 at exit.
// Depends on des_pkg; subkeys come in from the top level.
`timescale 1ns / 1ps
module des_round_pipe
  import des_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  logic                     in_dec_i,
  input  logic [BlockW-1:0]        in_block_i,
  input  logic [NumRounds-1:0][47:0] subkeys_i,
  output logic                     out_valid_o,
  output logic [BlockW-1:0]        out_block_o
);

  logic [NumRounds-1:0]       vld_q;
  logic [NumRounds-1:0]       dec_q;
  logic [NumRounds-1:0][31:0] l_q, r_q;
  logic [63:0]                ip_blk;

  assign ip_blk = perm_ip(in_block_i);

  // Stage s holds the state after round s; the stall freezes the whole line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NumRounds-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dec_q[0] <= in_dec_i;
      l_q[0]   <= ip_blk[31:0];
      r_q[0]   <= ip_blk[63:32] ^
                  round_f(ip_blk[31:0], in_dec_i ? subkeys_i[NumRounds-1] : subkeys_i[0]);
      for (int s = 1; s < NumRounds; s++) begin
        dec_q[s] <= dec_q[s-1];
        l_q[s]   <= r_q[s-1];
        r_q[s]   <= l_q[s-1] ^
                    round_f(r_q[s-1], dec_q[s-1] ? subkeys_i[NumRounds-1-s] : subkeys_i[s]);
      end
    end
  end

  assign out_valid_o = vld_q[NumRounds-1];
  assign out_block_o = perm_ipinv({r_q[NumRounds-1], l_q[NumRounds-1]});

endmodule

// ----- rtl/des_block_cipher_top.sv -----
// DES block cipher top level: APB key register, subkey schedule, round pipeline.
// Depends on des_pkg and des_round_pipe.
`timescale 1ns / 1ps
// One 64-bit block enters per cycle unless the output stalls; the result passes
// through one register stage per Feistel round. The 16 subkeys are wired
// from des_key (byte address 0, 64-bit APB data) through PC1, the rotations and
// PC2, so a new key applies at once to every block in flight; write the key only
// while no transaction is in flight. Back-pressure on the output stalls the
// whole pipeline.
module des_block_cipher_top
  import des_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [0:0]        paddr,
  input  logic [KeyW-1:0]   pwdata,
  output logic [KeyW-1:0]   prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [BlockW-1:0] data_block_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BlockW-1:0] result_block_o
);

  logic [KeyW-1:0]              key_q;
  logic [NumRounds-1:0][47:0]   sk;
  logic [NumRounds-1:0][27:0]   c_n, d_n;
  logic [55:0]                  cd0;
  logic                         adv;
  logic                         pv;
  logic                         key_wr;

  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? key_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_wr) begin
      key_q <= pwdata;
    end
  end

  // Key schedule is pure rewiring: PC1, rotations and PC2.
  assign cd0 = perm_pc1(key_q);
  always_comb begin
    c_n[0] = rot28(cd0[55:28], RotTab[0]);
    d_n[0] = rot28(cd0[27:0],  RotTab[0]);
    for (int i = 1; i < NumRounds; i++) begin
      c_n[i] = rot28(c_n[i-1], RotTab[i]);
      d_n[i] = rot28(d_n[i-1], RotTab[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NumRounds; i++) sk[i] = perm_pc2({c_n[i], d_n[i]});
  end

  assign adv        = out_ready_i || !pv;
  assign in_ready_o = adv;

  des_round_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .in_dec_i    (cmd_i),
    .in_block_i  (data_block_i),
    .subkeys_i   (sk),
    .out_valid_o (pv),
    .out_block_o (result_block_o)
  );

  assign out_valid_o = pv;

endmodule
